// ===== rtl/wht_pkg.sv =====
// ----------------------------------------------------------------------------
// wht_pkg
// Shared types and constants for the window hit-test and raise table.
// ----------------------------------------------------------------------------
package wht_pkg;

	localparam int WINDOW_SLOTS_DEF = 16;

	// frame around the client area
	localparam int TITLE_BAR = 24;
	localparam int FRAME     = 2;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_HIT   = 2'd1;
	localparam logic [1:0] CMD_RAISE = 2'd2;

	localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic commit;
		logic emit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic needs_scan;
		logic scan_done;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [15:0]        id;
		logic signed [14:0] left;
		logic signed [14:0] top;
		logic [13:0]        width;
		logic [13:0]        height;
		logic               shown;
	} rec_t;

endpackage

// ===== rtl/wht_ctrl.sv =====
// ----------------------------------------------------------------------------
// wht_ctrl
// Command sequencer: accept, slot scan, commit of a raise, result hand-off.
// ----------------------------------------------------------------------------
module wht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  wht_pkg::sts_t sts,
	output wht_pkg::ctl_t ctl
);
	import wht_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.needs_scan ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				// last read is folded in on the edge that leaves this state
				if (sts.scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				ctl.accept = in_valid;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
			end
			ST_COMMIT: begin
				ctl.commit = 1'b1;
			end
			ST_EMIT: begin
				ctl.emit = sts.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

// ===== rtl/wht_datapath.sv =====
// ----------------------------------------------------------------------------
// wht_datapath
// Slot memories, one-slot-per-cycle scan with hit and id compare, focus
// register, count register and the result register.
// ----------------------------------------------------------------------------
module wht_datapath #(
	parameter int WINDOW_SLOTS = wht_pkg::WINDOW_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wht_pkg::ctl_t      ctl,
	output wht_pkg::sts_t      sts,
	input  logic [1:0]         cmd,
	input  logic [3:0]         slot,
	input  logic [15:0]        win_ident,
	input  logic signed [14:0] left_x,
	input  logic signed [14:0] top_y,
	input  logic [13:0]        area_width,
	input  logic [13:0]        area_height,
	input  logic               shown,
	input  logic [15:0]        depth,
	input  logic [13:0]        point_x,
	input  logic [13:0]        point_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [3:0]         hit_slot,
	output logic [15:0]        hit_id,
	output logic [15:0]        new_depth,
	output logic [15:0]        focused_id
);
	import wht_pkg::*;

	localparam int SW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int CW = $clog2(WINDOW_SLOTS + 1);

	// slot memories; entries not yet written read as zero via valid bits
	rec_t        rec_mem [WINDOW_SLOTS];
	logic [15:0] dep_mem [WINDOW_SLOTS];
	logic [WINDOW_SLOTS-1:0] vld_q;

	logic [4:0]    slot_limit_q;
	logic [CW-1:0] n_slots, idx_q;
	logic [31:0]   n_full;

	logic [1:0]    cmd_q;
	logic [15:0]   id_q;
	logic [13:0]   px_q, py_q;

	logic          rd_s1;
	logic [SW-1:0] addr_s1;
	rec_t          rec_s1;
	logic [15:0]   dep_s1;
	logic          vld_s1;

	logic          found_q;
	logic [SW-1:0] hslot_q;
	logic [15:0]   hid_q, ndepth_q, top_q, focus_q;

	logic          out_valid_q, out_found_q;
	logic [3:0]    out_slot_q;
	logic [15:0]   out_id_q, out_depth_q, out_focus_q;

	logic [SW+3:0] slot_ext, hslot_ext;
	logic [SW-1:0] slot_addr, rd_addr;
	logic          slot_ok, wr_rec, raise_wr, issue;
	logic          dep_we;
	logic [SW-1:0] dep_wa;
	logic [15:0]   dep_wd, raise_depth;

	rec_t               e_rec;
	logic [15:0]        e_dep;
	logic signed [16:0] px, py, x_lo, x_hi, y_lo, y_hi;
	logic               covers, hit_take, id_match;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= '0;
		end else if (cfg_valid) begin
			slot_limit_q <= cfg_data;
		end
	end

	// counts above the table size act as the table size
	assign n_full  = (32'(slot_limit_q) > 32'(WINDOW_SLOTS)) ?
		32'(WINDOW_SLOTS) : 32'(slot_limit_q);
	assign n_slots = n_full[CW-1:0];

	assign slot_ext  = {{SW{1'b0}}, slot};
	assign slot_addr = slot_ext[SW-1:0];
	assign slot_ok   = 32'(slot) < 32'(WINDOW_SLOTS);
	assign wr_rec    = ctl.accept && (cmd == CMD_WRITE) && slot_ok;

	assign raise_depth = (top_q == DEPTH_MAX) ? DEPTH_MAX : top_q + 16'd1;
	assign raise_wr    = ctl.commit && (cmd_q == CMD_RAISE) && found_q;

	assign dep_we = wr_rec || raise_wr;
	assign dep_wa = wr_rec ? slot_addr : hslot_q;
	assign dep_wd = wr_rec ? depth : raise_depth;

	assign issue   = ctl.scan && (idx_q < n_slots);
	assign rd_addr = idx_q[SW-1:0];

	always_ff @(posedge clk) begin
		if (wr_rec) begin
			rec_mem[slot_addr] <= '{id: win_ident, left: left_x, top: top_y,
				width: area_width, height: area_height, shown: shown};
		end else if (raise_wr && !vld_q[hslot_q]) begin
			// raised slot never written: its record stays all zero
			rec_mem[hslot_q] <= '0;
		end
		if (dep_we) begin
			dep_mem[dep_wa] <= dep_wd;
		end
		if (issue) begin
			rec_s1 <= rec_mem[rd_addr];
			dep_s1 <= dep_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_s1  <= 1'b0;
			rd_s1   <= 1'b0;
			addr_s1 <= '0;
		end else begin
			if (dep_we) begin
				vld_q[dep_wa] <= 1'b1;
			end
			rd_s1 <= issue;
			if (issue) begin
				vld_s1  <= vld_q[rd_addr];
				addr_s1 <= rd_addr;
			end
		end
	end

	assign e_rec = vld_s1 ? rec_s1 : '0;
	assign e_dep = vld_s1 ? dep_s1 : '0;

	// area = client area, frame left/right/below, title bar above
	assign px   = signed'({3'b000, px_q});
	assign py   = signed'({3'b000, py_q});
	assign x_lo = 17'(e_rec.left) - 17'(FRAME);
	assign x_hi = 17'(e_rec.left) + signed'({3'b000, e_rec.width}) + 17'(FRAME);
	assign y_lo = 17'(e_rec.top) - 17'(TITLE_BAR);
	assign y_hi = 17'(e_rec.top) + signed'({3'b000, e_rec.height}) + 17'(FRAME);

	assign covers   = (px >= x_lo) && (px < x_hi) && (py >= y_lo) && (py < y_hi);
	assign hit_take = e_rec.shown && covers && (!found_q || (e_dep >= ndepth_q));
	assign id_match = !found_q && (e_rec.id == id_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= CMD_WRITE;
			id_q     <= '0;
			px_q     <= '0;
			py_q     <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			hslot_q  <= '0;
			hid_q    <= '0;
			ndepth_q <= '0;
			top_q    <= '0;
			focus_q  <= '0;
		end else begin
			if (ctl.accept) begin
				cmd_q    <= cmd;
				id_q     <= win_ident;
				px_q     <= point_x;
				py_q     <= point_y;
				idx_q    <= '0;
				found_q  <= 1'b0;
				hslot_q  <= '0;
				hid_q    <= '0;
				ndepth_q <= '0;
				top_q    <= '0;
			end
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_s1) begin
				if (cmd_q == CMD_HIT) begin
					if (hit_take) begin
						found_q  <= 1'b1;
						hslot_q  <= addr_s1;
						hid_q    <= e_rec.id;
						ndepth_q <= e_dep;
					end
				end else begin
					if (id_match) begin
						found_q <= 1'b1;
						hslot_q <= addr_s1;
					end
					if (e_dep > top_q) begin
						top_q <= e_dep;
					end
				end
			end
			if (raise_wr) begin
				ndepth_q <= raise_depth;
				hid_q    <= id_q;
				focus_q  <= id_q;
			end
		end
	end

	assign hslot_ext = {4'b0000, hslot_q};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_found_q <= found_q;
			out_slot_q  <= hslot_ext[3:0];
			out_id_q    <= hid_q;
			out_depth_q <= ndepth_q;
			out_focus_q <= focus_q;
		end
	end

	assign sts.needs_scan = (cmd == CMD_HIT) || (cmd == CMD_RAISE);
	assign sts.scan_done  = !(idx_q < n_slots);
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign found      = out_found_q;
	assign hit_slot   = out_slot_q;
	assign hit_id     = out_id_q;
	assign new_depth  = out_depth_q;
	assign focused_id = out_focus_q;

endmodule

// ===== rtl/window_hit_test_and_raise_table.sv =====
// ----------------------------------------------------------------------------
// window_hit_test_and_raise_table
// Window record table with z-ordered point hit-test and raise-by-id.
// ----------------------------------------------------------------------------
// A write command needs no slot scan; a hit-test or raise scans n slots,
// n = min(slot limit, WINDOW_SLOTS), one slot per cycle, since the slot
// memory has one read port. The result register lets a new command be
// accepted while a result waits. Every command gives exactly one result;
// configuration is always ready.
module window_hit_test_and_raise_table #(
	parameter int WINDOW_SLOTS = wht_pkg::WINDOW_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [3:0]         slot,
	input  logic [15:0]        win_ident,
	input  logic signed [14:0] left_x,
	input  logic signed [14:0] top_y,
	input  logic [13:0]        area_width,
	input  logic [13:0]        area_height,
	input  logic               shown,
	input  logic [15:0]        depth,
	input  logic [13:0]        point_x,
	input  logic [13:0]        point_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [3:0]         hit_slot,
	output logic [15:0]        hit_id,
	output logic [15:0]        new_depth,
	output logic [15:0]        focused_id,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data
);
	import wht_pkg::*;

	ctl_t ctl;
	sts_t sts;

	wht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	wht_datapath #(
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd         (cmd),
		.slot        (slot),
		.win_ident   (win_ident),
		.left_x      (left_x),
		.top_y       (top_y),
		.area_width  (area_width),
		.area_height (area_height),
		.shown       (shown),
		.depth       (depth),
		.point_x     (point_x),
		.point_y     (point_y),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.hit_slot    (hit_slot),
		.hit_id      (hit_id),
		.new_depth   (new_depth),
		.focused_id  (focused_id)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the window hit-test and raise table. Slot writes,
// point probes and raise commands go in with random gaps while the result
// side stalls at random. A shadow window table predicts every result, and
// the bench checks each result in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
	import wht_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         SLOTS      = 16;

	typedef struct {
		logic [1:0]         op;
		logic [3:0]         slot;
		logic [15:0]        id;
		logic signed [14:0] left;
		logic signed [14:0] top;
		logic [13:0]        width;
		logic [13:0]        height;
		logic               vis;
		logic [15:0]        depth;
		logic [13:0]        px;
		logic [13:0]        py;
	} window_cmd_t;

	typedef struct {
		logic        found;
		logic [3:0]  slot;
		logic [15:0] id;
		logic [15:0] depth;
		logic [15:0] focus;
	} window_reply_t;

	// shadow of the window table plus the queue of replies still owed
	class window_table_tracker;
		logic [15:0]        ids[SLOTS];
		logic signed [14:0] lefts[SLOTS];
		logic signed [14:0] tops[SLOTS];
		logic [13:0]        widths[SLOTS];
		logic [13:0]        heights[SLOTS];
		logic               vis[SLOTS];
		logic [15:0]        depths[SLOTS];
		logic [15:0]        focus;
		logic [4:0]         count;
		window_reply_t      pending_replies[$];
		int                 errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				ids[i] = '0;
				lefts[i] = '0;
				tops[i] = '0;
				widths[i] = '0;
				heights[i] = '0;
				vis[i] = 1'b0;
				depths[i] = '0;
			end
			focus = '0;
			count = '0;
			errors = 0;
		endfunction

		function void set_count(logic [4:0] v);
			count = v;
		endfunction

		function int in_use();
			return (count > SLOTS) ? SLOTS : int'(count);
		endfunction

		// client area grown by the frame on three sides and the title bar above
		function bit covers(int s, int px, int py);
			int l, t, w, h;
			l = int'(lefts[s]);
			t = int'(tops[s]);
			w = int'(widths[s]);
			h = int'(heights[s]);
			return px >= l - FRAME && px < l + w + FRAME &&
				py >= t - TITLE_BAR && py < t + h + FRAME;
		endfunction

		function void accept_command(window_cmd_t c);
			window_reply_t r;
			int            n;
			int            tallest;
			r = '{found: 1'b0, slot: '0, id: '0, depth: '0, focus: '0};
			n = in_use();
			tallest = 0;
			case (c.op)
				CMD_WRITE: begin
					ids[c.slot] = c.id;
					lefts[c.slot] = c.left;
					tops[c.slot] = c.top;
					widths[c.slot] = c.width;
					heights[c.slot] = c.height;
					vis[c.slot] = c.vis;
					depths[c.slot] = c.depth;
				end
				CMD_HIT: begin
					// >= lets the later slot win a tie
					for (int i = 0; i < n; i++) begin
						if (vis[i] && covers(i, int'(c.px), int'(c.py)) &&
							(!r.found || depths[i] >= r.depth)) begin
							r.found = 1'b1;
							r.slot = 4'(i);
							r.id = ids[i];
							r.depth = depths[i];
						end
					end
				end
				CMD_RAISE: begin
					for (int i = 0; i < n; i++) begin
						if (!r.found && ids[i] == c.id) begin
							r.found = 1'b1;
							r.slot = 4'(i);
						end
						if (int'(depths[i]) > tallest)
							tallest = int'(depths[i]);
					end
					if (r.found) begin
						r.depth = (tallest >= int'(DEPTH_MAX)) ? DEPTH_MAX : 16'(tallest + 1);
						depths[r.slot] = r.depth;
						r.id = c.id;
						focus = c.id;
					end
				end
				default: ;
			endcase
			r.focus = focus;
			pending_replies.push_back(r);
		endfunction

		function void compare_field(string what, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what,
					want, got);
			end
		endfunction

		function void check_reply(window_reply_t got);
			window_reply_t want;
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none, actual id %0h",
					$time, got.id);
				return;
			end
			want = pending_replies.pop_front();
			compare_field("found", want.found, got.found);
			compare_field("hit_slot", want.slot, got.slot);
			compare_field("hit_id", want.id, got.id);
			compare_field("new_depth", want.depth, got.depth);
			compare_field("focused_id", want.focus, got.focus);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [3:0]         slot;
	logic [15:0]        win_ident;
	logic signed [14:0] left_x;
	logic signed [14:0] top_y;
	logic [13:0]        area_width;
	logic [13:0]        area_height;
	logic               shown;
	logic [15:0]        depth;
	logic [13:0]        point_x;
	logic [13:0]        point_y;
	logic               out_valid;
	logic               out_stall;
	logic               found;
	logic [3:0]         hit_slot;
	logic [15:0]        hit_id;
	logic [15:0]        new_depth;
	logic [15:0]        focused_id;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [4:0]         cfg_data;

	window_table_tracker board;
	bit                  quiet_phase = 1'b0;

	window_hit_test_and_raise_table uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : (v > 16383) ? 16383 : v;
	endfunction

	// every field random; commands override the ones they use
	function automatic window_cmd_t random_fields();
		window_cmd_t c;
		c.op = 2'($urandom);
		c.slot = 4'($urandom);
		c.id = 16'($urandom);
		c.left = 15'($urandom);
		c.top = 15'($urandom);
		c.width = 14'($urandom);
		c.height = 14'($urandom);
		c.vis = 1'($urandom);
		c.depth = 16'($urandom);
		c.px = 14'($urandom);
		c.py = 14'($urandom);
		return c;
	endfunction

	function automatic window_cmd_t make_write(int s, int id, int l, int t, int w, int h,
		bit v, int d);
		window_cmd_t c;
		c = random_fields();
		c.op = CMD_WRITE;
		c.slot = 4'(s);
		c.id = 16'(id);
		c.left = 15'(l);
		c.top = 15'(t);
		c.width = 14'(w);
		c.height = 14'(h);
		c.vis = v;
		c.depth = 16'(d);
		return c;
	endfunction

	function automatic window_cmd_t make_probe(int x, int y);
		window_cmd_t c;
		c = random_fields();
		c.op = CMD_HIT;
		c.px = 14'(x);
		c.py = 14'(y);
		return c;
	endfunction

	function automatic window_cmd_t make_raise(int id);
		window_cmd_t c;
		c = random_fields();
		c.op = CMD_RAISE;
		c.id = 16'(id);
		return c;
	endfunction

	// windows crowd a small area so that probes see overlaps and ties
	function automatic window_cmd_t random_command();
		window_cmd_t c;
		int          r, n, s, v;
		c = random_fields();
		n = board.in_use();
		r = $urandom_range(0, 99);
		if (r < 30) begin
			c.op = CMD_WRITE;
			if (n > 0 && $urandom_range(0, 3) != 0)
				c.slot = 4'($urandom_range(0, n - 1));
			if ($urandom_range(0, 9) != 0) begin
				v = $urandom_range(0, 660) - 30;
				c.left = 15'(v);
				v = $urandom_range(0, 500) - 30;
				c.top = 15'(v);
				c.width = 14'($urandom_range(0, 240));
				c.height = 14'($urandom_range(0, 240));
			end
			c.vis = ($urandom_range(0, 7) != 0);
			case ($urandom_range(0, 9))
				0: ;
				1: c.depth = DEPTH_MAX - 16'($urandom_range(0, 3));
				default: c.depth = 16'($urandom_range(0, 40));
			endcase
			if ($urandom_range(0, 7) != 0)
				c.id = 16'($urandom_range(1, 20));
		end else if (r < 75) begin
			c.op = CMD_HIT;
			if (n > 0 && $urandom_range(0, 4) != 0) begin
				s = $urandom_range(0, n - 1);
				v = int'(board.lefts[s]) - 3 +
					int'($urandom_range(0, int'(board.widths[s]) + 6));
				c.px = 14'(clamp_coord(v));
				v = int'(board.tops[s]) - 26 +
					int'($urandom_range(0, int'(board.heights[s]) + 30));
				c.py = 14'(clamp_coord(v));
			end else if ($urandom_range(0, 3) != 0) begin
				c.px = 14'($urandom_range(0, 700));
				c.py = 14'($urandom_range(0, 560));
			end
		end else if (r < 95) begin
			c.op = CMD_RAISE;
			if (n > 0 && $urandom_range(0, 9) < 7)
				c.id = board.ids[$urandom_range(0, n - 1)];
			else if ($urandom_range(0, 1) == 0)
				c.id = 16'($urandom_range(0, 20));
		end else begin
			c.op = CMD_UNUSED;
		end
		return c;
	endfunction

	function automatic logic [4:0] pick_count();
		case ($urandom_range(0, 9))
			0: return 5'd0;
			1: return 5'($urandom_range(17, 31));
			2: return 5'd16;
			3: return 5'd1;
			default: return 5'($urandom_range(2, 16));
		endcase
	endfunction

	// valid stays up after a transaction until the next call decides otherwise
	task automatic send_command(window_cmd_t c);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c.op;
		slot <= c.slot;
		win_ident <= c.id;
		left_x <= c.left;
		top_y <= c.top;
		area_width <= c.width;
		area_height <= c.height;
		shown <= c.vis;
		depth <= c.depth;
		point_x <= c.px;
		point_y <= c.py;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.accept_command(c);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// only written with the block drained
	task automatic write_slot_limit(logic [4:0] v);
		release_input();
		while (board.pending_replies.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_count(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : receiver
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && $urandom_range(0, 3) == 0)
				hold = pick_gap();
			out_stall <= (hold > 0);
			if (hold > 0)
				hold--;
		end
	end

	always @(posedge clk) begin
		window_reply_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.found = found;
			got.slot = hit_slot;
			got.id = hit_id;
			got.depth = new_depth;
			got.focus = focused_id;
			board.check_reply(got);
		end
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_WRITE;
		slot = '0;
		win_ident = '0;
		left_x = '0;
		top_y = '0;
		area_width = '0;
		area_height = '0;
		shown = 1'b0;
		depth = '0;
		point_x = '0;
		point_y = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, title bar and frame edges, ties, saturation
		write_slot_limit(5'd16);
		send_command(make_probe(0, 0));
		send_command(make_raise(0));
		send_command(make_write(0, 16'hFFFF, -16384, -16384, 16383, 16383, 1'b1, 0));
		send_command(make_write(15, 16'h0001, 16383, 16383, 0, 0, 1'b1, 16'hFFFF));
		send_command(make_write(3, 16'h1234, 100, 100, 50, 50, 1'b1, 7));
		send_command(make_write(4, 16'h1234, 120, 90, 10, 10, 1'b1, 7));
		send_command(make_write(5, 16'h0055, 0, 0, 16383, 16383, 1'b0, 16'hFFFF));
		send_command(make_probe(0, 0));
		send_command(make_probe(125, 95));
		send_command(make_probe(98, 76));
		send_command(make_probe(97, 76));
		send_command(make_probe(151, 151));
		send_command(make_probe(152, 152));
		send_command(make_probe(16383, 16383));
		send_command(make_raise(16'h1234));
		send_command(make_raise(16'hBEEF));
		begin
			window_cmd_t junk;
			junk = random_fields();
			junk.op = CMD_UNUSED;
			send_command(junk);
		end
		write_slot_limit(5'd0);
		send_command(make_probe(125, 95));
		send_command(make_raise(16'h1234));
		write_slot_limit(5'd31);
		send_command(make_probe(16383, 16383));
		send_command(make_raise(16'h0001));
		write_slot_limit(5'd1);
		send_command(make_probe(125, 95));

		for (int p = 0; p < 15; p++) begin
			quiet_phase = (p % 5 == 3);
			write_slot_limit((p == 0) ? 5'd16 : (p == 1) ? 5'd31 : pick_count());
			repeat (102) send_command(random_command());
		end

		release_input();
		while (board.pending_replies.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/wht_pkg.sv
rtl/wht_ctrl.sv
rtl/wht_datapath.sv
rtl/window_hit_test_and_raise_table.sv
tb/testbench.sv
